// ===== design/tcp_congestion_window_control_unit_macros.svh =====
// Assertion macros for the congestion window control unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TCP_CONGESTION_WINDOW_CONTROL_UNIT_MACROS_SVH
`define TCP_CONGESTION_WINDOW_CONTROL_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CWC_ASSERT_IMP(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CWC_ASSERT_NXT(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cwc_pkg.sv =====
// Shared types and constants for the congestion window control unit.
// No dependencies.
package cwc_pkg;

	localparam int SEGMENT_BYTES_DEF = 1024;
	localparam int MAX_CWND_DEF      = 1024;

	localparam int ACK_W    = 32;
	localparam int LEN_W    = 11;
	localparam int CWND_W   = 11;
	localparam int TH_W     = 21;
	localparam int RWND_W   = 21;
	localparam int REW_W    = 13;
	localparam int MODE_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 21;

	localparam int THRESH_MAX = 1048576;
	localparam int REWIND_MAX = 8191;
	localparam int THRESH_RST = 65536;
	localparam int BUF_RST    = 524288;
	localparam int DUP_LIMIT  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUF_SIZE    = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_SS = 2'd0,
		MODE_CA = 2'd1,
		MODE_FR = 2'd2
	} cwc_mode_t;

	typedef struct packed {
		logic              command;
		logic [ACK_W-1:0]  ack_num;
		logic [LEN_W-1:0]  seg_len;
	} cwc_in_t;

	typedef struct packed {
		logic [CWND_W-1:0] cwnd;
		logic [TH_W-1:0]   threshold;
		logic [MODE_W-1:0] cong_state;
		logic              round_done;
		logic [REW_W-1:0]  rewind_bytes;
		logic              transfer_done;
		logic [RWND_W-1:0] recv_window;
	} cwc_res_t;

endpackage

// ===== design/cwc_in_stage.sv =====
// Input register stage: captures one event word, drives the input stall.
// Depends on cwc_pkg.
module cwc_in_stage
	import cwc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  cwc_in_t word_in,
	input  logic    adv,
	output logic    valid_s1,
	output cwc_in_t word_s1
);

	logic accept;

	// stall only when the held word cannot move on this cycle
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= word_in;
		end
	end

endmodule

// ===== design/cwc_update.sv =====
// Congestion state registers, config registers and the per-event update.
// Depends on cwc_pkg.
module cwc_update
	import cwc_pkg::*;
#(
	parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF,
	parameter int MAX_CWND      = MAX_CWND_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  step,
	input  cwc_in_t               word,
	output cwc_res_t              res
);

	localparam int WIN_W  = $clog2(MAX_CWND + 1);
	localparam int SEG_W  = $clog2(SEGMENT_BYTES + 1);
	localparam int PROD_W = WIN_W + SEG_W;
	localparam int HALF_W = (PROD_W > TH_W) ? PROD_W : TH_W;
	localparam int QUO_W  = $clog2(((2 ** TH_W) - 1) / SEGMENT_BYTES + 1);
	localparam int EXT_W  = ((QUO_W > WIN_W) ? QUO_W : WIN_W) + 2;
	localparam int LC_W   = (LEN_W > SEG_W) ? LEN_W : SEG_W;
	localparam int RW_W   = LC_W + 3;
	localparam int HALF_CAP_Q = THRESH_MAX / SEGMENT_BYTES;
	// exact floor(x / SEGMENT_BYTES) for x < 2**TH_W by reciprocal multiply
	localparam int DIV_S  = TH_W + $clog2(SEGMENT_BYTES);
	localparam int DIV_MW = TH_W + 2;
	localparam int DIVP_W = TH_W + DIV_MW;
	localparam logic [DIV_MW-1:0] DIV_M = DIV_MW'(((64'd1 << DIV_S) +
		64'(SEGMENT_BYTES) - 64'd1) / 64'(SEGMENT_BYTES));

	function automatic logic [WIN_W-1:0] sat_win(input logic [EXT_W-1:0] v);
		logic [WIN_W-1:0] r;
		if (v > EXT_W'(MAX_CWND)) begin
			r = WIN_W'(MAX_CWND);
		end else if (v == '0) begin
			r = WIN_W'(1);
		end else begin
			r = v[WIN_W-1:0];
		end
		return r;
	endfunction

	// config register (the initial threshold lives only in thr_q)
	logic [RWND_W-1:0] buf_size_q;

	// congestion state
	cwc_mode_t         mode_q,   n_mode;
	logic [WIN_W-1:0]  window_q, n_window;
	logic [TH_W-1:0]   thr_q,    n_thr;
	logic [1:0]        dup_q,    n_dup;
	logic [ACK_W-1:0]  last_q,   n_last;
	logic [WIN_W-1:0]  slot_q,   n_slot;
	logic [RWND_W-1:0] rwnd_q,   n_rwnd;
	logic              fin_q,    n_fin;

	logic              round_done;
	logic [REW_W-1:0]  rewind;

	logic [PROD_W-1:0] prod_cur, prod_new;
	logic [HALF_W-1:0] half_ext;
	logic              half_clamp;
	logic [TH_W-1:0]   half_thr;
	logic [DIVP_W-1:0] div_prod;
	logic [QUO_W-1:0]  thr_quo;
	logic [EXT_W-1:0]  fr_base;
	logic [WIN_W-1:0]  win_dbl;
	logic [WIN_W:0]    slot_inc;
	logic              short_seg, full_seg, ack_dup, enter_fr;
	logic [1:0]        dup_inc;
	logic [RW_W-1:0]   rw_raw;
	logic [REW_W-1:0]  rw_sat;

	// window * segment, halved and clamped: new threshold on loss
	assign prod_cur   = PROD_W'(window_q) * PROD_W'(SEGMENT_BYTES);
	assign half_ext   = HALF_W'(prod_cur >> 1);
	assign half_clamp = half_ext > HALF_W'(THRESH_MAX);
	assign half_thr   = half_clamp ? TH_W'(THRESH_MAX) :
		(half_ext == '0) ? TH_W'(1) : half_ext[TH_W-1:0];
	// half_thr / SEGMENT_BYTES without a second multiply
	assign fr_base = half_clamp ? EXT_W'(HALF_CAP_Q) : EXT_W'(window_q >> 1);

	assign div_prod = DIVP_W'(thr_q) * DIVP_W'(DIV_M);
	assign thr_quo  = div_prod[DIV_S +: QUO_W];

	assign win_dbl  = sat_win(EXT_W'(window_q) << 1);
	assign prod_new = PROD_W'(win_dbl) * PROD_W'(SEGMENT_BYTES);

	assign short_seg = LC_W'(word.seg_len) < LC_W'(SEGMENT_BYTES);
	assign full_seg  = LC_W'(word.seg_len) == LC_W'(SEGMENT_BYTES);
	assign ack_dup   = word.ack_num == last_q;
	assign dup_inc   = dup_q + 2'd1;
	assign enter_fr  = (mode_q != MODE_FR) && ack_dup && (dup_inc == 2'(DUP_LIMIT));
	assign slot_inc  = {1'b0, slot_q} + 1'b1;

	// oversized segments take the short-segment formula
	assign rw_raw = full_seg ? RW_W'(4 * SEGMENT_BYTES) :
		RW_W'(word.seg_len) + RW_W'(3 * SEGMENT_BYTES);
	assign rw_sat = (rw_raw > RW_W'(REWIND_MAX)) ? REW_W'(REWIND_MAX) : rw_raw[REW_W-1:0];

	always_comb begin
		n_mode     = mode_q;
		n_window   = window_q;
		n_thr      = thr_q;
		n_dup      = dup_q;
		n_last     = last_q;
		n_slot     = slot_q;
		n_rwnd     = rwnd_q;
		n_fin      = fin_q;
		round_done = 1'b0;
		rewind     = '0;
		if (!fin_q) begin
			n_rwnd = (rwnd_q > RWND_W'(word.seg_len)) ?
				rwnd_q - RWND_W'(word.seg_len) : '0;
			if (word.command) begin
				// timeout: back to slow start
				n_thr      = half_thr;
				n_window   = WIN_W'(1);
				n_dup      = '0;
				n_mode     = MODE_SS;
				n_slot     = '0;
				round_done = 1'b1;
				n_fin      = short_seg;
			end else if (mode_q == MODE_FR && !ack_dup) begin
				// new ack ends fast recovery
				n_last     = word.ack_num;
				n_window   = sat_win(EXT_W'(thr_quo));
				n_dup      = '0;
				n_mode     = MODE_CA;
				n_slot     = '0;
				round_done = 1'b1;
				n_fin      = short_seg;
			end else begin
				if (mode_q != MODE_FR) begin
					n_dup = ack_dup ? dup_inc : 2'd0;
				end
				n_last = word.ack_num;
				if (enter_fr) begin
					n_dup      = '0;
					n_thr      = half_thr;
					n_window   = sat_win(fr_base + EXT_W'(3));
					n_rwnd     = buf_size_q;
					rewind     = rw_sat;
					n_mode     = MODE_FR;
					n_slot     = '0;
					round_done = 1'b1;
				end else if (short_seg) begin
					n_fin      = 1'b1;
					n_slot     = '0;
					round_done = 1'b1;
				end else if (slot_inc >= {1'b0, window_q}) begin
					n_slot     = '0;
					round_done = 1'b1;
					if (mode_q == MODE_CA) begin
						n_window = sat_win(EXT_W'(window_q) + EXT_W'(1));
					end else begin
						n_window = win_dbl;
						if (mode_q == MODE_SS &&
							HALF_W'(prod_new) >= HALF_W'(thr_q)) begin
							n_mode = MODE_CA;
						end
					end
				end else begin
					n_slot = slot_inc[WIN_W-1:0];
				end
			end
		end
	end

	always_comb begin
		res.cwnd          = CWND_W'(n_window);
		res.threshold     = n_thr;
		res.cong_state    = n_mode;
		res.round_done    = round_done;
		res.rewind_bytes  = rewind;
		res.transfer_done = n_fin;
		res.recv_window   = n_rwnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size_q <= RWND_W'(BUF_RST);
			mode_q     <= MODE_SS;
			window_q   <= WIN_W'(1);
			thr_q      <= TH_W'(THRESH_RST);
			dup_q      <= '0;
			last_q     <= '0;
			slot_q     <= '0;
			rwnd_q     <= RWND_W'(BUF_RST);
			fin_q      <= 1'b0;
		end else if (cfg_wr_en) begin
			// threshold goes straight to the live value; buffer size also loads the receive window
			case (cfg_index)
				CFG_INIT_THRESH: begin
					thr_q      <= cfg_data;
				end
				CFG_BUF_SIZE: begin
					buf_size_q <= cfg_data;
					rwnd_q     <= cfg_data;
				end
				default: begin
				end
			endcase
		end else if (step) begin
			mode_q   <= n_mode;
			window_q <= n_window;
			thr_q    <= n_thr;
			dup_q    <= n_dup;
			last_q   <= n_last;
			slot_q   <= n_slot;
			rwnd_q   <= n_rwnd;
			fin_q    <= n_fin;
		end
	end

endmodule

// ===== design/cwc_out_stage.sv =====
// Result register stage: holds one result word until the receiver takes it.
// Depends on cwc_pkg.
module cwc_out_stage
	import cwc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     avail,
	input  cwc_res_t res_in,
	output logic     take,
	input  logic     out_stall,
	output logic     valid_s2,
	output cwc_res_t res_s2
);

	// free when empty or being emptied this cycle
	assign take = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= avail;
		end
	end

	always_ff @(posedge clk) begin
		if (take && avail) begin
			res_s2 <= res_in;
		end
	end

endmodule

// ===== design/tcp_congestion_window_control_unit.sv =====
// Congestion window control unit (Reno style), top level.
// Depends on cwc_pkg, cwc_in_stage, cwc_update, cwc_out_stage and the macro header.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event word per slot:
//   command (0 ack, 1 timeout), ack_num and seg_len. Output channel
//   (out_valid / out_stall) returns exactly one result word per event:
//   cwnd, threshold, cong_state, round_done, rewind_bytes, transfer_done
//   and recv_window, in event order.
//   A word is taken at a clock edge where valid is high and stall is low.
//   An accepted word passes the input register, then the result register.
//   Throughput: one word per cycle while out_stall is low; the whole state update (window,
//   threshold, duplicate count, receive window) is one combinational pass
//   between the input register and the result register, and it closes on
//   itself every cycle.
//   Receiver stall: the result register holds; one more word waits in the
//   input register, then in_stall rises until out_stall drops.
//   Reset (arst_n low, asynchronous): slow start, window 1, threshold and
//   receive window from their reset values, both stages empty.
//   Config: cfg_wr_en with cfg_index (0 initial threshold, 1 buffer size)
//   writes cfg_data and loads the live copy too; write only
//   while no event is in flight.
`include "tcp_congestion_window_control_unit_macros.svh"

module tcp_congestion_window_control_unit
	import cwc_pkg::*;
#(
	parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF,
	parameter int MAX_CWND      = MAX_CWND_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// event channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  logic [ACK_W-1:0]      ack_num,
	input  logic [LEN_W-1:0]      seg_len,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CWND_W-1:0]     cwnd,
	output logic [TH_W-1:0]       threshold,
	output logic [MODE_W-1:0]     cong_state,
	output logic                  round_done,
	output logic [REW_W-1:0]      rewind_bytes,
	output logic                  transfer_done,
	output logic [RWND_W-1:0]     recv_window
);

	cwc_in_t  word_in, word_s1;
	cwc_res_t res_next, res_s2;
	logic     valid_s1, take, adv;

	assign word_in.command = command;
	assign word_in.ack_num = ack_num;
	assign word_in.seg_len = seg_len;

	// the event in the input register moves when the result register frees
	assign adv = valid_s1 && take;

	cwc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.word_in  (word_in),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	cwc_update #(
		.SEGMENT_BYTES (SEGMENT_BYTES),
		.MAX_CWND      (MAX_CWND)
	) u_upd (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (adv),
		.word      (word_s1),
		.res       (res_next)
	);

	cwc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (valid_s1),
		.res_in    (res_next),
		.take      (take),
		.out_stall (out_stall),
		.valid_s2  (out_valid),
		.res_s2    (res_s2)
	);

	assign cwnd          = res_s2.cwnd;
	assign threshold     = res_s2.threshold;
	assign cong_state    = res_s2.cong_state;
	assign round_done    = res_s2.round_done;
	assign rewind_bytes  = res_s2.rewind_bytes;
	assign transfer_done = res_s2.transfer_done;
	assign recv_window   = res_s2.recv_window;

	// input side backs up only when both stages are full and the sink stalls
	`CWC_ASSERT_IMP(a_stall_only_full, clk, arst_n, in_stall,
		valid_s1 && out_valid && out_stall, "in_stall without both stages full")
	// an advancing event always lands in the result register
	`CWC_ASSERT_NXT(a_adv_lands, clk, arst_n, adv, out_valid,
		"advanced event did not reach the result register")
	// a rewind only comes with a round end in fast recovery
	`CWC_ASSERT_IMP(a_rewind_fr, clk, arst_n, out_valid && rewind_bytes != '0,
		round_done && cong_state == MODE_FR, "rewind outside fast recovery entry")
	// end of transfer is sticky across delivered words
	`CWC_ASSERT_NXT(a_done_sticky, clk, arst_n, out_valid && !out_stall && transfer_done,
		!out_valid || transfer_done, "transfer_done dropped after end of transfer")

endmodule
